// ===== hdl/tths_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tths_pkg
// Shared types, sizes and codes of the timer task heap scheduler.
// ----------------------------------------------------------------------------
package tths_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int TASK_COUNT  = 64;
	localparam int TIME_BITS   = 48;

	localparam int ID_BITS    = 6;
	localparam int CNT_BITS   = 7;
	localparam int IDX_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int TIDX_BITS  = $clog2(TASK_COUNT);

	localparam logic [TIME_BITS-1:0] TIME_MAX     = {TIME_BITS{1'b1}};
	localparam logic [TIME_BITS-1:0] PERIOD_LIMIT = {2'b00, {(TIME_BITS-2){1'b1}}};

	typedef enum logic [2:0] {
		A_ONCE   = 3'd0,
		A_DELAY  = 3'd1,
		A_RATE   = 3'd2,
		A_TICK   = 3'd3,
		A_CTASK  = 3'd4,
		A_CTIMER = 3'd5,
		A_PURGE  = 3'd6,
		A_NONE   = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_DELAY = 3'd1,
		ST_BAD_PER   = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_CANCELLED = 3'd4,
		ST_NOT_NEW   = 3'd5,
		ST_FULL      = 3'd6,
		ST_SPARE     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		TS_NEW  = 2'd0,
		TS_SCHD = 2'd1,
		TS_EXEC = 2'd2,
		TS_CANC = 2'd3
	} task_state_t;

	// One classified command, passed from the front end to the heap engine.
	typedef struct packed {
		action_t              action;
		logic [ID_BITS-1:0]   task_id;
		logic [TIME_BITS-1:0] now_time;
		logic [TIME_BITS-1:0] due;
		logic [TIME_BITS-1:0] period;
		status_t              err;
	} cmd_t;

	// One heap slot; period is signed: zero one-shot, negative fixed delay.
	typedef struct packed {
		logic [TIME_BITS-1:0] due;
		logic [TIME_BITS-1:0] period;
		logic [ID_BITS-1:0]   task_id;
	} entry_t;

endpackage

// ===== hdl/tths_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tths_in_if / tths_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface tths_in_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      action;
	logic [tths_pkg::ID_BITS-1:0]    task_id;
	logic [tths_pkg::TIME_BITS-1:0]  now_time;
	logic signed [tths_pkg::TIME_BITS-1:0] delay;
	logic signed [tths_pkg::TIME_BITS-1:0] run_period;

	modport source (output valid, action, task_id, now_time, delay, run_period, input ready);
	modport sink   (input valid, action, task_id, now_time, delay, run_period, output ready);
endinterface

interface tths_out_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      status;
	logic                            fired;
	logic [tths_pkg::ID_BITS-1:0]    fired_task;
	logic [tths_pkg::TIME_BITS-1:0]  wait_time;
	logic [tths_pkg::CNT_BITS-1:0]   purged_count;
	logic [tths_pkg::CNT_BITS-1:0]   queue_count;

	modport source (output valid, status, fired, fired_task, wait_time, purged_count,
		queue_count, input ready);
	modport sink   (input valid, status, fired, fired_task, wait_time, purged_count,
		queue_count, output ready);
endinterface

// ===== hdl/tths_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tths_front
// Accepts command beats, checks schedule arguments and queues them.
// ----------------------------------------------------------------------------
module tths_front (
	input  logic           clk,
	input  logic           arst_n,
	tths_in_if.sink        item,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output tths_pkg::cmd_t cmd
);
	import tths_pkg::*;

	cmd_t                 fifo_q [2];
	logic                 wptr_q, rptr_q;
	logic [1:0]           fill_q;
	cmd_t                 cls;
	action_t              act;
	logic                 rep, neg, pbad, ovf, big;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] per, stored;
	logic                 push, pop;

	always_comb begin
		act  = action_t'(item.action);
		per  = item.run_period;
		rep  = (act == A_DELAY) || (act == A_RATE);
		neg  = item.delay[TIME_BITS-1];
		pbad = rep && (per[TIME_BITS-1] || (per == '0));
		sum  = {1'b0, item.now_time} + {1'b0, item.delay};
		ovf  = sum[TIME_BITS];
		big  = per > PERIOD_LIMIT;
		unique case (act)
			A_DELAY: stored = big ? ~((per + 1'b1) >> 1) + 1'b1 : ~per + 1'b1;
			A_RATE:  stored = big ? per >> 1 : per;
			default: stored = '0;
		endcase
		cls.action   = act;
		cls.task_id  = item.task_id;
		cls.now_time = item.now_time;
		cls.due      = sum[TIME_BITS-1:0];
		cls.period   = stored;
		priority if (neg)  cls.err = ST_BAD_DELAY;
		else if (pbad)     cls.err = ST_BAD_PER;
		else if (ovf)      cls.err = ST_OVERFLOW;
		else               cls.err = ST_OK;
	end

	assign item.ready = (fill_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign cmd_valid  = (fill_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hdl/tths_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tths_back
// Heap engine: task state table, min-heap memory and the sift sequencer.
// ----------------------------------------------------------------------------
module tths_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tths_pkg::cmd_t cmd,
	tths_out_if.source     result
);
	import tths_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE  = 19'd1 << 0,
		S_TSRD  = 19'd1 << 1,
		S_TSCHK = 19'd1 << 2,
		S_UP    = 19'd1 << 3,
		S_UPCMP = 19'd1 << 4,
		S_TTOP  = 19'd1 << 5,
		S_TTS   = 19'd1 << 6,
		S_TEVAL = 19'd1 << 7,
		S_RM    = 19'd1 << 8,
		S_RMW   = 19'd1 << 9,
		S_DN    = 19'd1 << 10,
		S_DNCMP = 19'd1 << 11,
		S_PRD   = 19'd1 << 12,
		S_PTS   = 19'd1 << 13,
		S_PCHK  = 19'd1 << 14,
		S_PHEAP = 19'd1 << 15,
		S_PJ    = 19'd1 << 16,
		S_PJL   = 19'd1 << 17,
		S_RESP  = 19'd1 << 18
	} state_t;

	// Heap memory, slots 1..QUEUE_DEPTH, two read ports and one write port.
	entry_t               heap_mem [QUEUE_DEPTH+1];
	entry_t               rd_a_q, rd_b_q;
	logic [IDX_BITS-1:0]  ha, hb, hw_a;
	logic                 hw_e;
	entry_t               hw_d;

	// Task state memory; an entry never written reads as new.
	task_state_t          ts_mem [TASK_COUNT];
	logic [TASK_COUNT-1:0] ts_vld_q;
	task_state_t          ts_rd_q, ts_cur;
	logic                 ts_rdv_q, ts_we;
	logic [TIDX_BITS-1:0] ts_ra, ts_wa;
	task_state_t          ts_wd;

	state_t               state_q, state_d, ret_q, ret_d;
	cmd_t                 cmd_q, cmd_d;
	logic [IDX_BITS-1:0]  count_q, count_d, k_q, k_d, i_q, i_d, j_q, j_d;
	logic                 acc_q, acc_d;
	entry_t               e_q, e_d, top_q, top_d, last_q, last_d, ch;
	logic [CNT_BITS-1:0]  purged_q, purged_d;
	status_t              status_q, status_d;
	logic                 fired_q, fired_d;
	logic [ID_BITS-1:0]   ftask_q, ftask_d;
	logic [TIME_BITS-1:0] wait_q, wait_d, negp;
	logic [TIME_BITS:0]   nt;
	logic [IDX_BITS:0]    c;
	logic                 pick_b, load;

	logic                 ov_q;
	logic [2:0]           o_status_q;
	logic                 o_fired_q;
	logic [ID_BITS-1:0]   o_ftask_q;
	logic [TIME_BITS-1:0] o_wait_q;
	logic [CNT_BITS-1:0]  o_purged_q, o_qc_q;

	always_ff @(posedge clk) begin
		if (hw_e) heap_mem[hw_a] <= hw_d;
		rd_a_q <= heap_mem[ha];
		rd_b_q <= heap_mem[hb];
		if (ts_we) ts_mem[ts_wa] <= ts_wd;
		ts_rd_q <= ts_mem[ts_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_vld_q <= '0;
			ts_rdv_q <= 1'b0;
		end else begin
			ts_rdv_q <= ts_vld_q[ts_ra];
			if (ts_we) ts_vld_q[ts_wa] <= 1'b1;
		end
	end

	assign ts_cur    = ts_rdv_q ? ts_rd_q : TS_NEW;
	assign cmd_ready = (state_q == S_IDLE);
	assign load      = (state_q == S_RESP) && (!ov_q || result.ready);
	assign c         = {k_q, 1'b0};
	assign pick_b    = (c < {1'b0, count_q}) && (rd_a_q.due > rd_b_q.due);
	assign ch        = pick_b ? rd_b_q : rd_a_q;
	assign negp      = ~top_q.period + 1'b1;

	always_comb begin
		if (top_q.period[TIME_BITS-1])
			nt = {1'b0, cmd_q.now_time} + {1'b0, negp};
		else
			nt = {1'b0, top_q.due} + {1'b0, top_q.period};
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cmd_d    = cmd_q;
		count_d  = count_q;
		k_d      = k_q;
		i_d      = i_q;
		j_d      = j_q;
		acc_d    = acc_q;
		e_d      = e_q;
		top_d    = top_q;
		last_d   = last_q;
		purged_d = purged_q;
		status_d = status_q;
		fired_d  = fired_q;
		ftask_d  = ftask_q;
		wait_d   = wait_q;
		ha       = '0;
		hb       = '0;
		hw_e     = 1'b0;
		hw_a     = k_q;
		hw_d     = e_q;
		ts_ra    = cmd_q.task_id[TIDX_BITS-1:0];
		ts_we    = 1'b0;
		ts_wa    = cmd_q.task_id[TIDX_BITS-1:0];
		ts_wd    = TS_CANC;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_d    = cmd;
					status_d = ST_OK;
					fired_d  = 1'b0;
					ftask_d  = '0;
					wait_d   = '0;
					purged_d = '0;
					state_d  = S_RESP;
					unique case (cmd.action)
						A_ONCE, A_DELAY, A_RATE: begin
							priority if (cmd.err != ST_OK) status_d = cmd.err;
							else if (!acc_q) status_d = ST_CANCELLED;
							else if (int'(cmd.task_id) >= TASK_COUNT) status_d = ST_NOT_NEW;
							else state_d = S_TSRD;
						end
						A_TICK: state_d = S_TTOP;
						A_CTASK: begin
							if (int'(cmd.task_id) < TASK_COUNT) begin
								ts_we = 1'b1;
								ts_wa = cmd.task_id[TIDX_BITS-1:0];
								ts_wd = TS_CANC;
							end
						end
						A_CTIMER: begin
							acc_d   = 1'b0;
							count_d = '0;
						end
						A_PURGE: begin
							i_d     = count_q;
							state_d = S_PRD;
						end
						default: state_d = S_RESP;
					endcase
				end
			end
			S_TSRD: state_d = S_TSCHK;
			S_TSCHK: begin
				priority if (ts_cur != TS_NEW) begin
					status_d = ST_NOT_NEW;
					state_d  = S_RESP;
				end else if (int'(count_q) >= QUEUE_DEPTH) begin
					status_d = ST_FULL;
					state_d  = S_RESP;
				end else begin
					ts_we   = 1'b1;
					ts_wd   = TS_SCHD;
					count_d = count_q + 1'b1;
					k_d     = count_q + 1'b1;
					e_d     = '{due: cmd_q.due, period: cmd_q.period, task_id: cmd_q.task_id};
					state_d = S_UP;
				end
			end
			S_UP: begin
				if (k_q == IDX_BITS'(1)) begin
					hw_e    = 1'b1;
					state_d = S_RESP;
				end else begin
					ha      = k_q >> 1;
					state_d = S_UPCMP;
				end
			end
			S_UPCMP: begin
				hw_e = 1'b1;
				if (rd_a_q.due <= e_q.due) begin
					state_d = S_RESP;
				end else begin
					hw_d    = rd_a_q;
					k_d     = k_q >> 1;
					state_d = S_UP;
				end
			end
			S_TTOP: begin
				if (count_q == '0) begin
					state_d = S_RESP;
				end else begin
					ha      = IDX_BITS'(1);
					state_d = S_TTS;
				end
			end
			S_TTS: begin
				ts_ra   = rd_a_q.task_id[TIDX_BITS-1:0];
				top_d   = rd_a_q;
				state_d = S_TEVAL;
			end
			S_TEVAL: begin
				priority if (ts_cur == TS_CANC) begin
					ret_d   = S_TTOP;
					state_d = S_RM;
				end else if (top_q.due <= cmd_q.now_time) begin
					fired_d = 1'b1;
					ftask_d = top_q.task_id;
					ret_d   = S_RESP;
					if (top_q.period == '0) begin
						ts_we   = 1'b1;
						ts_wa   = top_q.task_id[TIDX_BITS-1:0];
						ts_wd   = TS_EXEC;
						state_d = S_RM;
					end else begin
						e_d     = top_q;
						e_d.due = nt[TIME_BITS] ? TIME_MAX : nt[TIME_BITS-1:0];
						k_d     = IDX_BITS'(1);
						state_d = S_DN;
					end
				end else begin
					wait_d  = top_q.due - cmd_q.now_time;
					state_d = S_RESP;
				end
			end
			S_RM: begin
				ha      = count_q;
				state_d = S_RMW;
			end
			S_RMW: begin
				e_d     = rd_a_q;
				count_d = count_q - 1'b1;
				k_d     = IDX_BITS'(1);
				state_d = S_DN;
			end
			S_DN: begin
				if (c > {1'b0, count_q}) begin
					hw_e    = 1'b1;
					state_d = ret_q;
				end else begin
					ha      = c[IDX_BITS-1:0];
					hb      = IDX_BITS'(c + 1'b1);
					state_d = S_DNCMP;
				end
			end
			S_DNCMP: begin
				hw_e = 1'b1;
				if (e_q.due <= ch.due) begin
					state_d = ret_q;
				end else begin
					hw_d    = ch;
					k_d     = pick_b ? IDX_BITS'(c + 1'b1) : c[IDX_BITS-1:0];
					state_d = S_DN;
				end
			end
			S_PRD: begin
				if (i_q == '0) begin
					state_d = S_PHEAP;
				end else begin
					ha      = i_q;
					hb      = count_q;
					state_d = S_PTS;
				end
			end
			S_PTS: begin
				ts_ra   = rd_a_q.task_id[TIDX_BITS-1:0];
				last_d  = rd_b_q;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (ts_cur == TS_CANC) begin
					hw_e     = 1'b1;
					hw_a     = i_q;
					hw_d     = last_q;
					count_d  = count_q - 1'b1;
					purged_d = purged_q + 1'b1;
				end
				i_d     = i_q - 1'b1;
				state_d = S_PRD;
			end
			S_PHEAP: begin
				j_d     = count_q >> 1;
				state_d = (purged_q == '0) ? S_RESP : S_PJ;
			end
			S_PJ: begin
				if (j_q == '0) begin
					state_d = S_RESP;
				end else begin
					ha      = j_q;
					state_d = S_PJL;
				end
			end
			S_PJL: begin
				e_d     = rd_a_q;
				k_d     = j_q;
				j_d     = j_q - 1'b1;
				ret_d   = S_PJ;
				state_d = S_DN;
			end
			S_RESP: if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		k_q      <= k_d;
		i_q      <= i_d;
		j_q      <= j_d;
		e_q      <= e_d;
		top_q    <= top_d;
		last_q   <= last_d;
		purged_q <= purged_d;
		status_q <= status_d;
		fired_q  <= fired_d;
		ftask_q  <= ftask_d;
		wait_q   <= wait_d;
		ret_q    <= ret_d;
		if (load) begin
			o_status_q <= status_q;
			o_fired_q  <= fired_q;
			o_ftask_q  <= ftask_q;
			o_wait_q   <= wait_q;
			o_purged_q <= purged_q;
			o_qc_q     <= CNT_BITS'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			acc_q   <= 1'b1;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			acc_q   <= acc_d;
			if (load)              ov_q <= 1'b1;
			else if (result.ready) ov_q <= 1'b0;
		end
	end

	assign result.valid        = ov_q;
	assign result.status       = o_status_q;
	assign result.fired        = o_fired_q;
	assign result.fired_task   = o_ftask_q;
	assign result.wait_time    = o_wait_q;
	assign result.purged_count = o_purged_q;
	assign result.queue_count  = o_qc_q;
endmodule

// ===== hdl/timer_task_heap_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_task_heap_scheduler_top
// Timer task scheduler on a binary min-heap, with a command queue in front.
// ----------------------------------------------------------------------------
// Sequence per command: a rejected schedule or a cancel goes straight to the result; an
// insert sifts up one level at a time; a tick that waits reads the top only; a tick that fires
// sifts the re-timed top down (periodic) or removes it (one-shot), after dropping each
// cancelled task found at the top; a purge scans every slot, then rebuilds the heap if it dropped any.
// Throughput: one command at a time in the heap engine; the next beat waits for the result.
// Reset: asynchronous, active low; empties the heap, marks every task new
// through per-task valid bits at once and re-opens scheduling.
module timer_task_heap_scheduler_top (
	input  logic     clk,
	input  logic     arst_n,
	tths_in_if.sink  item,
	tths_out_if.source result
);
	import tths_pkg::*;

	// The front end classifies each beat and holds up to two; the heap engine
	// drains them at its own pace, so either side may stall independently.
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	tths_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// The heap engine holds its result in an output register until taken.
	tths_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.result    (result)
	);
endmodule

// ===== hdl/tths_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tths_checker
// Port-level checks on the result channel of the scheduler.
// ----------------------------------------------------------------------------
module tths_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               ov,
	input logic                               ord,
	input logic [2:0]                         status,
	input logic                               fired,
	input logic [tths_pkg::TIME_BITS-1:0]     wait_time,
	input logic [tths_pkg::CNT_BITS-1:0]      purged,
	input logic [tths_pkg::CNT_BITS-1:0]      qc
);
	import tths_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !ord |=> ov && $stable(status) && $stable(qc))
		else $error("result beat changed while stalled");

	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		ov && fired |-> status == ST_OK && wait_time == '0 && purged == '0)
		else $error("fired beat carries other results");

	a_purge: assert property (@(posedge clk) disable iff (!arst_n)
		ov && purged != '0 |-> status == ST_OK && !fired && wait_time == '0)
		else $error("purge beat carries other results");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		ov |-> int'(qc) + int'(purged) <= QUEUE_DEPTH)
		else $error("heap count beyond depth");
endmodule

bind timer_task_heap_scheduler_top tths_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.ov        (result.valid),
	.ord       (result.ready),
	.status    (result.status),
	.fired     (result.fired),
	.wait_time (result.wait_time),
	.purged    (result.purged_count),
	.qc        (result.queue_count)
);
